>>> design/bresenham_line_rasterizer_unit_defines.svh
// Assertion macros shared by the line rasteriser modules.
// No dependencies; included by files that carry concurrent checks.
`ifndef BRESENHAM_LINE_RASTERIZER_UNIT_DEFINES_SVH
`define BRESENHAM_LINE_RASTERIZER_UNIT_DEFINES_SVH

// Plain property, sampled on the rising clock, off during reset.
`define BRL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define BRL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/brl_pkg.sv
// Shared constants and types for the line rasteriser.
// No dependencies.
package brl_pkg;

  localparam int TILE_SIZE = 64;
  localparam int COORD_W   = 6;
  localparam int ERR_W     = COORD_W + 2;
  localparam int MINOR_W   = COORD_W + 2;
  localparam int CMD_DEPTH = 2;
  localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  // One classified line command, major axis rising.
  typedef struct packed {
    logic               steep;
    logic [COORD_W-1:0] maj_start;
    logic [COORD_W-1:0] maj_end;
    logic [COORD_W-1:0] min_start;
    logic               min_up;
    logic [COORD_W-1:0] minor_span;
    logic [COORD_W-1:0] major_span;
  } brl_cmd_t;

  typedef enum logic {
    WALK_IDLE,
    WALK_RUN
  } brl_walk_state_e;

endpackage

>>> design/brl_front.sv
// Front end: clamps endpoints, picks the major axis and orders the ends.
// Depends on brl_pkg.
module brl_front (
  input  logic [brl_pkg::COORD_W-1:0] start_x_i,
  input  logic [brl_pkg::COORD_W-1:0] start_y_i,
  input  logic [brl_pkg::COORD_W-1:0] end_x_i,
  input  logic [brl_pkg::COORD_W-1:0] end_y_i,
  output brl_pkg::brl_cmd_t           cmd_o
);
  import brl_pkg::*;

  function automatic logic [COORD_W-1:0] clamp_in(input logic [COORD_W-1:0] v);
    logic [COORD_W-1:0] r;
    if (int'(v) >= TILE_SIZE) begin
      r = COORD_W'(TILE_SIZE - 1);
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [COORD_W-1:0] ax, ay, bx, by, dx, dy;
  logic [COORD_W-1:0] p0_maj, p0_min, p1_maj, p1_min;
  logic [COORD_W-1:0] maj_s, maj_e, min_s, min_e;
  logic               steep, swap, up;

  always_comb begin
    ax = clamp_in(start_x_i);
    ay = clamp_in(start_y_i);
    bx = clamp_in(end_x_i);
    by = clamp_in(end_y_i);
    dx = (ax > bx) ? (ax - bx) : (bx - ax);
    dy = (ay > by) ? (ay - by) : (by - ay);
    steep = dy > dx;

    p0_maj = steep ? ay : ax;
    p0_min = steep ? ax : ay;
    p1_maj = steep ? by : bx;
    p1_min = steep ? bx : by;

    swap  = p0_maj > p1_maj;
    maj_s = swap ? p1_maj : p0_maj;
    maj_e = swap ? p0_maj : p1_maj;
    min_s = swap ? p1_min : p0_min;
    min_e = swap ? p0_min : p1_min;
    up    = min_e > min_s;

    cmd_o.steep      = steep;
    cmd_o.maj_start  = maj_s;
    cmd_o.maj_end    = maj_e;
    cmd_o.min_start  = min_s;
    cmd_o.min_up     = up;
    cmd_o.minor_span = up ? (min_e - min_s) : (min_s - min_e);
    cmd_o.major_span = maj_e - maj_s;
  end

endmodule

>>> design/brl_cmd_queue.sv
// Short command queue between the front end and the pixel walker.
// Depends on brl_pkg and the assertion macro header.
`include "bresenham_line_rasterizer_unit_defines.svh"

module brl_cmd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  brl_pkg::brl_cmd_t wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output brl_pkg::brl_cmd_t rdata_o,
  output logic              empty_o
);
  import brl_pkg::*;

  brl_cmd_t             entry_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CMD_CNT_W-1:0] count_q, count_d;

  function automatic logic [CMD_PTR_W-1:0] ptr_inc(input logic [CMD_PTR_W-1:0] p);
    logic [CMD_PTR_W-1:0] r;
    if (int'(p) == CMD_DEPTH - 1) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign full_o  = (int'(count_q) == CMD_DEPTH);
  assign empty_o = (count_q == '0);
  assign rdata_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= wdata_i;
    end
  end

  `BRL_ASSERT(a_no_pop_empty, clk_i, rst_ni, pop_i |-> !empty_o, "pop from empty command queue")
  `BRL_ASSERT(a_no_push_full, clk_i, rst_ni, push_i |-> !full_o, "push into full command queue")

endmodule

>>> design/brl_walker.sv
// Back end: walks one command a pixel per cycle into the output register, holding while a stalled pixel waits there.
// Depends on brl_pkg and the assertion macro header.
`include "bresenham_line_rasterizer_unit_defines.svh"

module brl_walker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  brl_pkg::brl_cmd_t           cmd_i,
  input  logic                        cmd_empty_i,
  output logic                        cmd_pop_o,
  output logic [brl_pkg::COORD_W-1:0] pixel_x_o,
  output logic [brl_pkg::COORD_W-1:0] pixel_y_o,
  output logic                        last_pixel_o,
  output logic                        out_valid_o,
  input  logic                        out_pop_i
);
  import brl_pkg::*;

  localparam logic signed [MINOR_W-1:0] MinorMax = MINOR_W'(TILE_SIZE - 1);

  function automatic logic [COORD_W-1:0] clamp_out(input logic signed [MINOR_W-1:0] v);
    logic [COORD_W-1:0] r;
    if (v[MINOR_W-1]) begin
      r = '0;
    end else if (v > MinorMax) begin
      r = COORD_W'(TILE_SIZE - 1);
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  brl_walk_state_e state_q, state_d;

  logic                      steep_q, up_q;
  logic [COORD_W-1:0]        major_q, maj_end_q, minor_span_q, major_span_q;
  logic signed [MINOR_W-1:0] minor_q, minor_d;
  logic signed [ERR_W-1:0]   err_q, err_d, err_sub;
  logic                      out_valid_q, out_valid_d;
  logic [COORD_W-1:0]        px_q, py_q, px_d, py_d;
  logic                      last_q;
  logic                      load, emit, is_last, minor_step;
  logic [COORD_W-1:0]        minor_px;

  always_comb begin
    state_d   = state_q;
    load      = 1'b0;
    emit      = 1'b0;
    cmd_pop_o = 1'b0;
    case (state_q)
      WALK_IDLE: begin
        if (!cmd_empty_i) begin
          load      = 1'b1;
          cmd_pop_o = 1'b1;
          state_d   = WALK_RUN;
        end
      end
      WALK_RUN: begin
        emit = !out_valid_q || out_pop_i;
        if (emit && is_last) begin
          state_d = WALK_IDLE;
        end
      end
      default: state_d = WALK_IDLE;
    endcase
  end

  always_comb begin
    is_last    = (major_q == maj_end_q);
    err_sub    = err_q - $signed({2'b00, minor_span_q});
    minor_step = err_sub[ERR_W-1] || (err_sub == '0);
    err_d      = minor_step ? (err_sub + $signed({2'b00, major_span_q})) : err_sub;
    minor_d    = minor_q;
    if (minor_step) begin
      minor_d = up_q ? (minor_q + MINOR_W'(1)) : (minor_q - MINOR_W'(1));
    end
    minor_px    = clamp_out(minor_q);
    px_d        = steep_q ? minor_px : major_q;
    py_d        = steep_q ? major_q : minor_px;
    out_valid_d = emit || (out_valid_q && !out_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= WALK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      steep_q      <= cmd_i.steep;
      up_q         <= cmd_i.min_up;
      major_q      <= cmd_i.maj_start;
      maj_end_q    <= cmd_i.maj_end;
      minor_span_q <= cmd_i.minor_span;
      major_span_q <= cmd_i.major_span;
      minor_q      <= $signed({2'b00, cmd_i.min_start});
      err_q        <= $signed({3'b000, cmd_i.major_span[COORD_W-1:1]});
    end else if (emit) begin
      major_q <= is_last ? major_q : (major_q + 1'b1);
      minor_q <= minor_d;
      err_q   <= err_d;
    end
    if (emit) begin
      px_q   <= px_d;
      py_q   <= py_d;
      last_q <= is_last;
    end
  end

  assign pixel_x_o    = px_q;
  assign pixel_y_o    = py_q;
  assign last_pixel_o = last_q;
  assign out_valid_o  = out_valid_q;

  `BRL_ASSERT(a_err_range, clk_i, rst_ni, (state_q == WALK_RUN) |-> (!err_q[ERR_W-1] && (err_q <= $signed({2'b00, major_span_q}))), "error term left its range")
  `BRL_ASSERT(a_major_bound, clk_i, rst_ni, (state_q == WALK_RUN) |-> (major_q <= maj_end_q), "major coordinate ran past the line end")
  `BRL_ASSERT_NEXT(a_last_ends, clk_i, rst_ni, emit && is_last, (state_q == WALK_IDLE) && last_pixel_o, "walker did not stop after the last pixel")

endmodule

>>> design/bresenham_line_rasterizer_unit.sv
// Top level of the line rasteriser: front end, command queue, pixel walker.
// Depends on brl_pkg, brl_front, brl_cmd_queue and brl_walker.
//
// Usage
//   Command side: a queue write port. Drive the four endpoint coordinates
//   and raise push; the item is taken at a rising edge with push high and
//   full low. Endpoints at or beyond the tile edge are clamped to it.
//   Pixel side: a queue read port. While empty is low the oldest pixel is
//   on pixel_x_o/pixel_y_o with last_pixel_o marking the end of its line;
//   pulse pop to take it.
//   Timing: a command is classified as it is written and sits in a
//   two-entry queue. The walker loads a command only when idle, then
//   emits one pixel per cycle while the output is not stalled; a line
//   has N = major span + 1 pixels, at most 64. For an idle walker the first
//   pixel passes the queue entry, the walker's load and the output register.
//   Stalls: if pop stays low the output register holds its pixel and the
//   walker waits; commands keep being taken until the queue fills, then
//   full rises.
//   Reset (rst_ni low, asynchronous) empties the queue, drops any line in
//   progress and clears the output valid flag.
module bresenham_line_rasterizer_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [brl_pkg::COORD_W-1:0] start_x_i,
  input  logic [brl_pkg::COORD_W-1:0] start_y_i,
  input  logic [brl_pkg::COORD_W-1:0] end_x_i,
  input  logic [brl_pkg::COORD_W-1:0] end_y_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [brl_pkg::COORD_W-1:0] pixel_x_o,
  output logic [brl_pkg::COORD_W-1:0] pixel_y_o,
  output logic                        last_pixel_o
);
  import brl_pkg::*;

  brl_cmd_t front_cmd, queue_cmd;
  logic     q_full, q_empty, q_pop, q_push;
  logic     out_valid;

  // Classification is purely combinational on the incoming item
  brl_front u_front (
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .cmd_o     (front_cmd)
  );

  assign q_push = push && !q_full;

  brl_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (front_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (queue_cmd),
    .empty_o (q_empty)
  );

  // Walker owns the output register; pop only counts while a pixel waits
  brl_walker u_walker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (queue_cmd),
    .cmd_empty_i  (q_empty),
    .cmd_pop_o    (q_pop),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .last_pixel_o (last_pixel_o),
    .out_valid_o  (out_valid),
    .out_pop_i    (pop)
  );

  assign full  = q_full;
  assign empty = !out_valid;

endmodule
